@@ rtl/tlqe_pkg.sv @@
// Shared types, constants and helpers for the thick line quad expander.
// No dependencies; every other file in rtl imports this package.
package tlqe_pkg;

  localparam int unsigned POS_W      = 24;  // Q15.8 coordinate
  localparam int unsigned MAG_W      = 24;  // |end - start|
  localparam int unsigned SQ_W       = 2 * MAG_W;
  localparam int unsigned RAD_W      = 64;  // radicand, (dx^2 + dy^2) << 12
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned REM_W      = ROOT_W + 4;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned QUO_W      = 16;  // twice the Q1.14 direction
  localparam int unsigned DREM_W     = ROOT_W + 1;
  localparam int unsigned DIV_STEPS  = QUO_W;
  localparam int unsigned UMAG_W     = 15;
  localparam int unsigned EXT_W      = 17;  // half width plus margin
  localparam int unsigned PROD_W     = UMAG_W + EXT_W;
  localparam int unsigned OFS_W      = 18;  // signed offset
  localparam int unsigned CW         = POS_W + 2;
  localparam int unsigned AA_W       = 10;
  localparam int unsigned VERTS      = 6;
  localparam int unsigned VCNT_W     = 3;
  localparam logic [AA_W-1:0] AA_RESET = 10'd256;

  localparam logic signed [CW-1:0] POS_MAX = 26'sd8388607;
  localparam logic signed [CW-1:0] POS_MIN = -26'sd8388608;

  // Item fields that ride alongside the arithmetic
  typedef struct packed {
    logic [POS_W-1:0] sx;
    logic [POS_W-1:0] sy;
    logic [POS_W-1:0] ex;
    logic [POS_W-1:0] ey;
    logic [15:0]      hw;
    logic [31:0]      color;
    logic             zero;
    logic             neg_x;
    logic             neg_y;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
  } tlqe_side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } tlqe_sqrt_t;

  typedef struct packed {
    logic [ROOT_W-1:0] den;
    logic [DREM_W-1:0] rem_x;
    logic [DREM_W-1:0] rem_y;
    logic [QUO_W-1:0]  q_x;
    logic [QUO_W-1:0]  q_y;
  } tlqe_div_t;

  typedef struct packed {
    logic [3:0][POS_W-1:0] cx;
    logic [3:0][POS_W-1:0] cy;
    tlqe_side_t            side;
  } tlqe_quad_t;

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [CW-1:0] v);
    logic [POS_W-1:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX[POS_W-1:0];
    end else if (v < POS_MIN) begin
      r = POS_MIN[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // Quad corner for each of the six vertices: 0,1,2,1,2,3
  function automatic logic [1:0] corner_of(input logic [VCNT_W-1:0] k);
    logic [1:0] c;
    case (k)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd1;
      3'd4:    c = 2'd2;
      3'd5:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/tlqe_sqrt_cell.sv @@
// One cell of the square root chain: resolves one root bit per stage.
// Depends on tlqe_pkg.
module tlqe_sqrt_cell import tlqe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  tlqe_sqrt_t data_i,
  input  tlqe_side_t side_i,
  output logic       valid_o,
  output tlqe_sqrt_t data_o,
  output tlqe_side_t side_o
);

  logic [REM_W-1:0] r2;
  logic [REM_W-1:0] trial;
  tlqe_sqrt_t       data_d;
  logic             valid_q;
  tlqe_sqrt_t       data_q;
  tlqe_side_t       side_q;

  always_comb begin
    r2            = {data_i.rem[REM_W-3:0], data_i.rad[RAD_W-1 -: 2]};
    trial         = {2'b00, data_i.root, 2'b01};
    data_d.rad    = {data_i.rad[RAD_W-3:0], 2'b00};
    if (r2 >= trial) begin
      data_d.rem  = r2 - trial;
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_d.rem  = r2;
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign side_o  = side_q;

endmodule

@@ rtl/tlqe_div_cell.sv @@
// One cell of the direction divider: one quotient bit for x and y per stage.
// Depends on tlqe_pkg.
module tlqe_div_cell import tlqe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  tlqe_div_t  data_i,
  input  tlqe_side_t side_i,
  output logic       valid_o,
  output tlqe_div_t  data_o,
  output tlqe_side_t side_o
);

  logic [DREM_W-1:0] rx;
  logic [DREM_W-1:0] ry;
  logic [DREM_W-1:0] dd;
  tlqe_div_t         data_d;
  logic              valid_q;
  tlqe_div_t         data_q;
  tlqe_side_t        side_q;

  // Numerator bits below the initial remainder are all zero
  always_comb begin
    rx         = {data_i.rem_x[DREM_W-2:0], 1'b0};
    ry         = {data_i.rem_y[DREM_W-2:0], 1'b0};
    dd         = {1'b0, data_i.den};
    data_d.den = data_i.den;
    if (rx >= dd) begin
      data_d.rem_x = rx - dd;
      data_d.q_x   = {data_i.q_x[QUO_W-2:0], 1'b1};
    end else begin
      data_d.rem_x = rx;
      data_d.q_x   = {data_i.q_x[QUO_W-2:0], 1'b0};
    end
    if (ry >= dd) begin
      data_d.rem_y = ry - dd;
      data_d.q_y   = {data_i.q_y[QUO_W-2:0], 1'b1};
    end else begin
      data_d.rem_y = ry;
      data_d.q_y   = {data_i.q_y[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign side_o  = side_q;

endmodule

@@ rtl/tlqe_vertex_emit.sv @@
// Output stage: holds one finished quad and hands out its six vertices.
// Depends on tlqe_pkg.
module tlqe_vertex_emit import tlqe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  tlqe_quad_t       quad_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [POS_W-1:0] corner_x_o,
  output logic [POS_W-1:0] corner_y_o,
  output logic [POS_W-1:0] line_start_x_o,
  output logic [POS_W-1:0] line_start_y_o,
  output logic [POS_W-1:0] line_end_x_o,
  output logic [POS_W-1:0] line_end_y_o,
  output logic [31:0]      vertex_color_o,
  output logic [15:0]      vertex_width_o,
  output logic [1:0]       corner_index_o,
  output logic             last_o
);

  logic              valid_q;
  logic [VCNT_W-1:0] cnt_q;
  tlqe_quad_t        quad_q;
  logic              is_last;
  logic [1:0]        corner;

  assign is_last = (cnt_q == VCNT_W'(VERTS - 1));
  assign corner  = corner_of(cnt_q);
  assign ready_o = !valid_q || (is_last && !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      cnt_q   <= '0;
    end else if (valid_q && !out_stall_i) begin
      if (is_last) begin
        valid_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quad_q <= quad_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign corner_x_o     = quad_q.cx[corner];
  assign corner_y_o     = quad_q.cy[corner];
  assign line_start_x_o = quad_q.side.sx;
  assign line_start_y_o = quad_q.side.sy;
  assign line_end_x_o   = quad_q.side.ex;
  assign line_end_y_o   = quad_q.side.ey;
  assign vertex_color_o = quad_q.side.color;
  assign vertex_width_o = quad_q.side.hw;
  assign corner_index_o = corner;
  assign last_o         = is_last;

endmodule

@@ rtl/thick_line_quad_expand_unit.sv @@
// Thick line quad expander: one segment in, six triangle vertices out (corners 0,1,2,1,2,3).
// The direction is normalised by a chain of 32 square root cells followed by 16 divider cells,
// with three setup and three offset stages around them before a segment reaches the output
// register. The chain takes a new segment every cycle unless held; the single vertex port,
// which hands out six vertices per segment, sets the sustained rate. The whole chain holds
// while its last stage waits for the output register.
module thick_line_quad_expand_unit import tlqe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // segment input
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [POS_W-1:0] start_x_i,
  input  logic [POS_W-1:0] start_y_i,
  input  logic [POS_W-1:0] end_x_i,
  input  logic [POS_W-1:0] end_y_i,
  input  logic [15:0]      half_width_i,
  input  logic [31:0]      color_rgba_i,
  // vertex output
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [POS_W-1:0] corner_x_o,
  output logic [POS_W-1:0] corner_y_o,
  output logic [POS_W-1:0] line_start_x_o,
  output logic [POS_W-1:0] line_start_y_o,
  output logic [POS_W-1:0] line_end_x_o,
  output logic [POS_W-1:0] line_end_y_o,
  output logic [31:0]      vertex_color_o,
  output logic [15:0]      vertex_width_o,
  output logic [1:0]       corner_index_o,
  output logic             last_o
);

  logic [AA_W-1:0] aa_q;
  logic            en;
  logic            emit_ready;
  logic            load;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aa_q <= AA_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      aa_q <= pwdata[AA_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - AA_W){1'b0}}, aa_q} : 32'd0;

  // ---------------- setup stages ----------------
  logic       v0_q, v1_q, v2_q;
  tlqe_side_t s0_q, s1_q, s1_d, s2_q;
  logic signed [POS_W:0] dx, dy;
  logic [SQ_W-1:0] sqx_q, sqy_q;

  always_comb begin
    s1_d       = s0_q;
    dx         = $signed({s0_q.ex[POS_W-1], s0_q.ex}) - $signed({s0_q.sx[POS_W-1], s0_q.sx});
    dy         = $signed({s0_q.ey[POS_W-1], s0_q.ey}) - $signed({s0_q.sy[POS_W-1], s0_q.sy});
    s1_d.neg_x = dx[POS_W];
    s1_d.neg_y = dy[POS_W];
    s1_d.zero  = (dx == '0) && (dy == '0);
    s1_d.mag_x = dx[POS_W] ? MAG_W'(-dx) : MAG_W'(dx);
    s1_d.mag_y = dy[POS_W] ? MAG_W'(-dy) : MAG_W'(dy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q.sx    <= start_x_i;
      s0_q.sy    <= start_y_i;
      s0_q.ex    <= end_x_i;
      s0_q.ey    <= end_y_i;
      s0_q.hw    <= half_width_i;
      s0_q.color <= color_rgba_i;
      s0_q.zero  <= 1'b0;
      s0_q.neg_x <= 1'b0;
      s0_q.neg_y <= 1'b0;
      s0_q.mag_x <= '0;
      s0_q.mag_y <= '0;
      s1_q       <= s1_d;
      sqx_q      <= s1_q.mag_x * s1_q.mag_x;
      sqy_q      <= s1_q.mag_y * s1_q.mag_y;
      s2_q       <= s1_q;
    end
  end

  // ---------------- square root chain ----------------
  logic       sq_v    [SQRT_STEPS+1];
  tlqe_sqrt_t sq_data [SQRT_STEPS+1];
  tlqe_side_t sq_side [SQRT_STEPS+1];
  logic [SQ_W:0] lsq;

  assign lsq             = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign sq_v[0]         = v2_q;
  assign sq_data[0].rad  = RAD_W'({lsq, 12'd0});
  assign sq_data[0].rem  = '0;
  assign sq_data[0].root = '0;
  assign sq_side[0]      = s2_q;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    tlqe_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .data_i  (sq_data[i]),
      .side_i  (sq_side[i]),
      .valid_o (sq_v[i+1]),
      .data_o  (sq_data[i+1]),
      .side_o  (sq_side[i+1])
    );
  end

  // ---------------- divider chain ----------------
  logic       dv_v    [DIV_STEPS+1];
  tlqe_div_t  dv_data [DIV_STEPS+1];
  tlqe_side_t dv_side [DIV_STEPS+1];

  // Numerator is mag << 21; the top bits above the 16 quotient bits seed the remainder
  assign dv_v[0]          = sq_v[SQRT_STEPS];
  assign dv_data[0].den   = sq_data[SQRT_STEPS].root;
  assign dv_data[0].rem_x = DREM_W'({sq_side[SQRT_STEPS].mag_x, 5'd0});
  assign dv_data[0].rem_y = DREM_W'({sq_side[SQRT_STEPS].mag_y, 5'd0});
  assign dv_data[0].q_x   = '0;
  assign dv_data[0].q_y   = '0;
  assign dv_side[0]       = sq_side[SQRT_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    tlqe_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[j]),
      .data_i  (dv_data[j]),
      .side_i  (dv_side[j]),
      .valid_o (dv_v[j+1]),
      .data_o  (dv_data[j+1]),
      .side_o  (dv_side[j+1])
    );
  end

  // ---------------- offsets and corners ----------------
  logic [QUO_W:0]  tx1, ty1;
  logic [UMAG_W-1:0] ux, uy;
  logic [EXT_W-1:0]  ext;
  logic              vm_q, vo_q, vc_q;
  logic [PROD_W-1:0] px_q, py_q;
  tlqe_side_t        sm_q, so_q;
  logic [PROD_W:0]   rx, ry;
  logic [EXT_W-1:0]  omx, omy;
  logic signed [OFS_W-1:0] ox_d, oy_d, ox_q, oy_q;
  tlqe_quad_t        quad_d, quad_q;

  // Round half away: floor(2m/d) + 1, halved
  assign tx1 = {1'b0, dv_data[DIV_STEPS].q_x} + 1'b1;
  assign ty1 = {1'b0, dv_data[DIV_STEPS].q_y} + 1'b1;
  assign ux  = tx1[UMAG_W:1];
  assign uy  = ty1[UMAG_W:1];
  assign ext = {1'b0, dv_side[DIV_STEPS].hw} + {{(EXT_W - AA_W){1'b0}}, aa_q};

  assign rx   = {1'b0, px_q} + (PROD_W+1)'(8192);
  assign ry   = {1'b0, py_q} + (PROD_W+1)'(8192);
  assign omx  = rx[14 +: EXT_W];
  assign omy  = ry[14 +: EXT_W];
  assign ox_d = sm_q.neg_x ? -$signed({1'b0, omx}) : $signed({1'b0, omx});
  assign oy_d = sm_q.neg_y ? -$signed({1'b0, omy}) : $signed({1'b0, omy});

  always_comb begin
    logic signed [CW-1:0] sx, sy, ex, ey, ox, oy, w;
    sx = CW'($signed(so_q.sx));
    sy = CW'($signed(so_q.sy));
    ex = CW'($signed(so_q.ex));
    ey = CW'($signed(so_q.ey));
    ox = CW'(ox_q);
    oy = CW'(oy_q);
    w  = $signed({{(CW - 16){1'b0}}, so_q.hw});
    quad_d.side = so_q;
    if (so_q.zero) begin
      quad_d.cx[0] = sat_pos(sx + w);  quad_d.cy[0] = sat_pos(sy + w);
      quad_d.cx[1] = sat_pos(sx + w);  quad_d.cy[1] = sat_pos(sy - w);
      quad_d.cx[2] = sat_pos(sx - w);  quad_d.cy[2] = sat_pos(sy + w);
      quad_d.cx[3] = sat_pos(sx - w);  quad_d.cy[3] = sat_pos(sy - w);
    end else begin
      quad_d.cx[0] = sat_pos(sx - ox - oy);  quad_d.cy[0] = sat_pos(sy - oy + ox);
      quad_d.cx[1] = sat_pos(ex + ox - oy);  quad_d.cy[1] = sat_pos(ey + oy + ox);
      quad_d.cx[2] = sat_pos(sx - ox + oy);  quad_d.cy[2] = sat_pos(sy - oy - ox);
      quad_d.cx[3] = sat_pos(ex + ox + oy);  quad_d.cy[3] = sat_pos(ey + oy - ox);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vo_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      vm_q <= dv_v[DIV_STEPS];
      vo_q <= vm_q;
      vc_q <= vo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q   <= ux * ext;
      py_q   <= uy * ext;
      sm_q   <= dv_side[DIV_STEPS];
      ox_q   <= ox_d;
      oy_q   <= oy_d;
      so_q   <= sm_q;
      quad_q <= quad_d;
    end
  end

  // Advance the chain unless its last stage is full and the output register cannot take it
  assign en         = !vc_q || emit_ready;
  assign load       = vc_q && emit_ready;
  assign in_stall_o = !en;

  tlqe_vertex_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .quad_i         (quad_q),
    .ready_o        (emit_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .corner_x_o     (corner_x_o),
    .corner_y_o     (corner_y_o),
    .line_start_x_o (line_start_x_o),
    .line_start_y_o (line_start_y_o),
    .line_end_x_o   (line_end_x_o),
    .line_end_y_o   (line_end_y_o),
    .vertex_color_o (vertex_color_o),
    .vertex_width_o (vertex_width_o),
    .corner_index_o (corner_index_o),
    .last_o         (last_o)
  );

  // ---------------- assertions ----------------
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> corner_index_o == 2'd3)
    else $error("last vertex is not corner 3");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> vc_q && !emit_ready)
    else $error("input stalled with room in the chain");

  a_first_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> corner_index_o == 2'd0 && !last_o)
    else $error("segment does not open on corner 0");

endmodule

@@ dv/thick_line_quad_expand_unit_test.sv @@
// Self-checking bench for the thick line quad expander: segments in, six vertices out.
// Predicts every vertex in plain integer arithmetic; depends on tlqe_pkg and the unit only.
`timescale 1ns / 100ps
module thick_line_quad_expand_unit_test;
  import tlqe_pkg::*;

  localparam logic [2:0] AA_ADDR = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;  // no register here
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 80;

  typedef struct {
    logic [POS_W-1:0] cx;
    logic [POS_W-1:0] cy;
    logic [POS_W-1:0] sx;
    logic [POS_W-1:0] sy;
    logic [POS_W-1:0] ex;
    logic [POS_W-1:0] ey;
    logic [31:0]      color;
    logic [15:0]      hw;
    logic [1:0]       corner;
    logic             last;
  } vertex_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [POS_W-1:0] start_x_i = '0;
  logic [POS_W-1:0] start_y_i = '0;
  logic [POS_W-1:0] end_x_i = '0;
  logic [POS_W-1:0] end_y_i = '0;
  logic [15:0]      half_width_i = '0;
  logic [31:0]      color_rgba_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [POS_W-1:0] corner_x_o;
  logic [POS_W-1:0] corner_y_o;
  logic [POS_W-1:0] line_start_x_o;
  logic [POS_W-1:0] line_start_y_o;
  logic [POS_W-1:0] line_end_x_o;
  logic [POS_W-1:0] line_end_y_o;
  logic [31:0]      vertex_color_o;
  logic [15:0]      vertex_width_o;
  logic [1:0]       corner_index_o;
  logic             last_o;

  vertex_t     vertex_q[$];
  logic [9:0]  margin = AA_RESET;
  int unsigned errors = 0;
  int unsigned segments_sent = 0;
  int unsigned vertices_seen = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  bit          gaps_on = 1'b1;

  thick_line_quad_expand_unit uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r, t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // nearest, ties away from zero
  function automatic longint div_round(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [POS_W-1:0] clamp24(longint v);
    if (v > 64'sd8388607) return 24'h7FFFFF;
    if (v < -64'sd8388608) return 24'h800000;
    return v[POS_W-1:0];
  endfunction

  function automatic void predict_vertices(logic [POS_W-1:0] sxr, syr, exr, eyr,
                                           logic [15:0] hw, logic [31:0] col);
    longint sx, sy, ex, ey, dx, dy, w, len64, ux, uy, e, ox, oy;
    longint cx[4], cy[4];
    int ord[6];
    vertex_t v;
    ord = '{0, 1, 2, 1, 2, 3};
    sx = longint'(signed'(sxr)); sy = longint'(signed'(syr));
    ex = longint'(signed'(exr)); ey = longint'(signed'(eyr));
    w = hw;
    dx = ex - sx;
    dy = ey - sy;
    if (dx == 0 && dy == 0) begin
      cx[0] = sx + w; cy[0] = sy + w;
      cx[1] = sx + w; cy[1] = sy - w;
      cx[2] = sx - w; cy[2] = sy + w;
      cx[3] = sx - w; cy[3] = sy - w;
    end else begin
      len64 = longint'(isqrt((dx * dx + dy * dy) << 12));
      ux = div_round(dx * 1048576, len64);
      uy = div_round(dy * 1048576, len64);
      e = w + margin;
      ox = div_round(ux * e, 16384);
      oy = div_round(uy * e, 16384);
      cx[0] = sx - ox - oy; cy[0] = sy - oy + ox;
      cx[1] = ex + ox - oy; cy[1] = ey + oy + ox;
      cx[2] = sx - ox + oy; cy[2] = sy - oy - ox;
      cx[3] = ex + ox + oy; cy[3] = ey + oy - ox;
    end
    for (int k = 0; k < 6; k++) begin
      v.cx = clamp24(cx[ord[k]]);
      v.cy = clamp24(cy[ord[k]]);
      v.sx = sxr; v.sy = syr; v.ex = exr; v.ey = eyr;
      v.color = col;
      v.hw = hw;
      v.corner = 2'(ord[k]);
      v.last = (k == 5);
      vertex_q.push_back(v);
    end
  endfunction

  // call just after a rising edge; returns just after the accepting edge, or after the random gap that follows it
  task automatic send_segment(logic [POS_W-1:0] sx, sy, ex, ey, logic [15:0] hw,
                              logic [31:0] col);
    int unsigned gap;
    start_x_i <= sx; start_y_i <= sy; end_x_i <= ex; end_y_i <= ey;
    half_width_i <= hw; color_rgba_i <= col;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_vertices(sx, sy, ex, ey, hw, col);
    segments_sent++;
    if (burst_left > 0) burst_left--;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_access(bit wr, logic [2:0] addr, logic [31:0] data, output logic [31:0] rd);
    psel <= 1'b1; penable <= 1'b0; pwrite <= wr; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_margin(logic [9:0] m);
    logic [31:0] rd;
    drain();
    reg_access(1'b1, AA_ADDR, {22'd0, m}, rd);
    margin = m;
    // a write to an empty slot must leave the margin alone
    reg_access(1'b1, SPARE_ADDR, $urandom, rd);
    reg_access(1'b0, AA_ADDR, '0, rd);
    if (rd[9:0] !== m) begin
      $error("aa_margin readback: expected %0d, actual %0d", m, rd[9:0]);
      errors++;
    end
  endtask

  task automatic random_segment();
    logic [POS_W-1:0] sx, sy, ex, ey;
    logic [15:0] hw;
    sx = 24'($urandom); sy = 24'($urandom);
    hw = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047));
    case ($urandom_range(0, 9))
      0, 1: begin ex = 24'($urandom); ey = 24'($urandom); end
      2: begin ex = sx; ey = sy; end
      3: begin ex = 24'(sx + $urandom_range(0, 8192) - 4096); ey = sy; end
      4: begin ex = sx; ey = 24'(sy + $urandom_range(0, 8192) - 4096); end
      5: begin
        sx = $urandom_range(0, 1) ? 24'(24'h7FFFFF - $urandom_range(0, 600))
                                  : 24'(24'h800000 + $urandom_range(0, 600));
        ex = 24'(sx + $urandom_range(0, 64) - 32); ey = 24'(sy + $urandom_range(0, 64) - 32);
        hw = 16'($urandom);
      end
      6: begin
        ex = 24'(sx + $urandom_range(0, 2) - 1); ey = 24'(sy + $urandom_range(0, 2) - 1);
      end
      default: begin
        ex = 24'(sx + $urandom_range(0, 131072) - 65536);
        ey = 24'(sy + $urandom_range(0, 131072) - 65536);
      end
    endcase
    send_segment(sx, sy, ex, ey, hw, $urandom);
  endtask

  task automatic test_directed();
    gaps_on = 1'b0;
    send_segment('0, '0, '0, '0, '0, '0);
    send_segment(24'h000100, 24'h000200, 24'h000100, 24'h000200, 16'hFFFF, 32'hFFFFFFFF);
    send_segment(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 32'h12345678);
    send_segment(24'h800000, 24'h800000, 24'h800000, 24'h800000, 16'h0100, 32'h0);
    send_segment(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 16'hFFFF, 32'hA5A5A5A5);
    send_segment(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 16'h0000, 32'h5A5A5A5A);
    send_segment(24'h000000, 24'h000000, 24'h001000, 24'h000000, 16'h0200, 32'h01020304);
    send_segment(24'h000000, 24'h000000, 24'h000000, 24'hFFF000, 16'h0200, 32'h0);
    send_segment(24'h000000, 24'h000000, 24'h000100, 24'h000100, 16'h0080, 32'h0);
    send_segment(24'h000010, 24'hFFFFF0, 24'h000011, 24'hFFFFF0, 16'h0001, 32'h0);
    send_segment(24'h7FFF00, 24'h000000, 24'h7FFFFF, 24'h000000, 16'hFFFF, 32'h0);
    send_segment(24'h800100, 24'h000000, 24'h800000, 24'h000010, 16'hFFFF, 32'h0);
    gaps_on = 1'b1;
  endtask

  task automatic test_margin_extremes();
    set_margin(10'd0);
    repeat (12) random_segment();
    set_margin(10'd1023);
    send_segment(24'h7FFF00, 24'h7FFF00, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 32'hFFFFFFFF);
    send_segment(24'h800000, 24'h000000, 24'h800001, 24'h000000, 16'hFFFF, 32'h0);
    repeat (10) random_segment();
  endtask

  task automatic test_random();
    for (int p = 0; p < 4; p++) begin
      set_margin(p == 0 ? AA_RESET : 10'($urandom));
      gaps_on = (p != 2);
      repeat (95) random_segment();
    end
  endtask

  // vertex checker and receiver stall pattern
  always @(posedge clk_i) begin
    vertex_t v;
    cycles++;
    if (cycles % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= (cycles % 8) < 5;
    endcase
    if (rst_ni && out_valid_o && !out_stall_i) begin
      vertices_seen++;
      if (vertex_q.size() == 0) begin
        $error("vertex with nothing expected: corner_x %0h", corner_x_o);
        errors++;
      end else begin
        v = vertex_q.pop_front();
        if (corner_x_o !== v.cx) begin
          $error("corner_x: expected %0h, actual %0h", v.cx, corner_x_o); errors++;
        end
        if (corner_y_o !== v.cy) begin
          $error("corner_y: expected %0h, actual %0h", v.cy, corner_y_o); errors++;
        end
        if (line_start_x_o !== v.sx) begin
          $error("line_start_x: expected %0h, actual %0h", v.sx, line_start_x_o); errors++;
        end
        if (line_start_y_o !== v.sy) begin
          $error("line_start_y: expected %0h, actual %0h", v.sy, line_start_y_o); errors++;
        end
        if (line_end_x_o !== v.ex) begin
          $error("line_end_x: expected %0h, actual %0h", v.ex, line_end_x_o); errors++;
        end
        if (line_end_y_o !== v.ey) begin
          $error("line_end_y: expected %0h, actual %0h", v.ey, line_end_y_o); errors++;
        end
        if (vertex_color_o !== v.color) begin
          $error("vertex_color: expected %0h, actual %0h", v.color, vertex_color_o); errors++;
        end
        if (vertex_width_o !== v.hw) begin
          $error("vertex_width: expected %0h, actual %0h", v.hw, vertex_width_o); errors++;
        end
        if (corner_index_o !== v.corner) begin
          $error("corner_index: expected %0d, actual %0d", v.corner, corner_index_o); errors++;
        end
        if (last_o !== v.last) begin
          $error("last: expected %0d, actual %0d", v.last, last_o); errors++;
        end
      end
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_margin_extremes();
    test_random();
    drain();
    if (vertex_q.size() != 0) errors++;
    $display("%0d segments sent, %0d vertices checked, margins 0, 256, 1023 and random,",
             segments_sent, vertices_seen);
    $display("zero-length, saturating and random segments under input gaps and output stalls");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
